// ===== design/qemi_pkg.sv =====
// Shared types, codes and command/status bundles for the quartic extension unit.
`timescale 1ns / 1ps

package qemi_pkg;

    localparam int FIELD_W   = 12;
    localparam int NUM_RED   = 9;
    localparam int RED_IDX_W = $clog2(NUM_RED);

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_INV = 1'b1;

    typedef logic signed [FIELD_W-1:0] coef_t;

    typedef struct packed {
        logic  opcode;
        coef_t a0;
        coef_t a1;
        coef_t a2;
        coef_t a3;
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t b3;
        coef_t alpha;
    } in_t;

    typedef struct packed {
        coef_t c0;
        coef_t c1;
        coef_t c2;
        coef_t c3;
        logic  zero_operand;
    } out_t;

    typedef enum logic [1:0] {
        MM_RED,
        MM_PROD,
        MM_ALPHA
    } mm_sel_t;

    typedef struct packed {
        logic                 load;
        logic                 mm_start;
        mm_sel_t              mm_sel;
        logic                 red_write;
        logic [RED_IDX_W-1:0] red_idx;
        logic                 t_clear;
        logic                 acc_step;
        logic                 yx_step;
        logic                 x_rot;
        logic                 y_from_c;
        logic                 y_from_x;
        logic                 t_to_c;
        logic                 t_to_x;
        logic                 e_shift;
        logic                 out_load;
        logic                 out_zero;
    } dp_cmd_t;

    typedef struct packed {
        logic mm_valid;
        logic invert;
        logic x_zero;
        logic e_zero;
        logic e_lsb;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== design/qemi_mulmod.sv =====
// Five-stage modular multiplier with Barrett reduction and signed-input fixup.
`timescale 1ns / 1ps

module qemi_mulmod #(
    parameter int  MODULUS_Q = 3457,
    localparam int W         = $clog2(MODULUS_Q + 1),
    localparam int XW        = (W > 12) ? W : 12
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [XW-1:0] x,
    input  logic [W-1:0]  y,
    input  logic          neg,
    output logic          valid,
    output logic [W-1:0]  res
);

    localparam int    PW    = XW + W;
    localparam int    MW    = XW + 2;
    localparam int    RW    = W + 2;
    localparam longint MRED = (64'd1 << PW) / MODULUS_Q;
    localparam int    C4096 = 4096 % MODULUS_Q;

    localparam logic [MW-1:0] MC  = MW'(MRED);
    localparam logic [W-1:0]  QC  = W'(MODULUS_Q);
    localparam logic [RW-1:0] QR  = RW'(MODULUS_Q);
    localparam logic [RW-1:0] Q2R = RW'(2 * MODULUS_Q);
    localparam logic [W:0]    CN  = (W + 1)'(C4096);
    localparam logic [W:0]    QN  = (W + 1)'(MODULUS_Q);

    logic [4:0]      vld_reg;
    logic [3:0]      neg_reg;
    logic [PW-1:0]   p_reg;
    logic [PW-1:0]   p2_reg;
    logic [MW-1:0]   qe_reg;
    logic [RW-1:0]   r_reg;
    logic [W-1:0]    r4_reg;
    logic [W-1:0]    res_reg;

    logic [PW+MW-1:0] pm;
    logic [PW-1:0]    qq;
    logic [PW-1:0]    rd;
    logic [W-1:0]     r4_next;
    logic [W:0]       adj;

    always_comb begin
        pm = (PW + MW)'(p_reg) * (PW + MW)'(MC);
        qq = PW'(qe_reg) * PW'(QC);
        rd = p2_reg - qq;
        if (r_reg >= Q2R) begin
            r4_next = W'(r_reg - Q2R);
        end else if (r_reg >= QR) begin
            r4_next = W'(r_reg - QR);
        end else begin
            r4_next = W'(r_reg);
        end
        adj = {1'b0, r4_reg};
        if (neg_reg[3]) begin
            adj = {1'b0, r4_reg} - CN;
            if ({1'b0, r4_reg} < CN) begin
                adj = adj + QN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= {neg_reg[2:0], neg};
        p_reg   <= PW'(x) * PW'(y);
        p2_reg  <= p_reg;
        qe_reg  <= pm[PW+MW-1:PW];
        r_reg   <= rd[RW-1:0];
        r4_reg  <= r4_next;
        res_reg <= adj[W-1:0];
    end

    assign valid = vld_reg[4];
    assign res   = res_reg;

endmodule

// ===== design/qemi_datapath.sv =====
// Datapath: operand, rotating product and result registers around one shared mulmod.
`timescale 1ns / 1ps

module qemi_datapath #(
    parameter int MODULUS_Q = 3457
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  qemi_pkg::in_t       s_data,
    input  qemi_pkg::dp_cmd_t   cmd,
    output qemi_pkg::dp_status_t st,
    output logic                m_valid,
    input  logic                m_ready,
    output qemi_pkg::out_t      m_data
);

    import qemi_pkg::*;

    localparam int     W    = $clog2(MODULUS_Q + 1);
    localparam int     XW   = (W > 12) ? W : 12;
    localparam int     CW   = (W + 1 > FIELD_W) ? W + 1 : FIELD_W;
    localparam longint QL   = longint'(MODULUS_Q);
    localparam longint QQ   = QL * QL * QL * QL;
    localparam int     EW   = $clog2(QQ);
    localparam logic [EW-1:0] E_INIT = EW'(QQ - 64'd2);
    localparam logic [W-1:0]  HALF   = W'((MODULUS_Q - 1) / 2);
    localparam logic [W:0]    QN     = (W + 1)'(MODULUS_Q);

    logic [FIELD_W-1:0] raw_reg [NUM_RED];
    logic [W-1:0]       x_reg [4];
    logic [W-1:0]       y_reg [4];
    logic [W-1:0]       t_reg [4];
    logic [W-1:0]       c_reg [4];
    logic [W-1:0]       alpha_reg;
    logic [EW-1:0]      e_reg;
    logic               inv_reg;
    logic               m_valid_reg;
    out_t               out_reg;

    logic [XW-1:0] mm_x;
    logic [W-1:0]  mm_y;
    logic          mm_neg;
    logic          mm_valid;
    logic [W-1:0]  mm_res;
    logic [W:0]    acc_sum;

    function automatic coef_t center(input logic [W-1:0] r);
        logic [CW-1:0] v;
        begin
            v = CW'(r);
            if (r > HALF) begin
                v = v - CW'(MODULUS_Q);
            end
            return coef_t'(v[FIELD_W-1:0]);
        end
    endfunction

    always_comb begin
        case (cmd.mm_sel)
            MM_RED: begin
                mm_x   = XW'(raw_reg[0]);
                mm_y   = W'(1);
                mm_neg = raw_reg[0][FIELD_W-1];
            end
            MM_ALPHA: begin
                mm_x   = XW'(alpha_reg);
                mm_y   = y_reg[3];
                mm_neg = 1'b0;
            end
            default: begin
                mm_x   = XW'(x_reg[0]);
                mm_y   = y_reg[0];
                mm_neg = 1'b0;
            end
        endcase
        acc_sum = {1'b0, t_reg[0]} + {1'b0, mm_res};
        if (acc_sum >= QN) begin
            acc_sum = acc_sum - QN;
        end
    end

    qemi_mulmod #(
        .MODULUS_Q(MODULUS_Q)
    ) u_mulmod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.mm_start),
        .x      (mm_x),
        .y      (mm_y),
        .neg    (mm_neg),
        .valid  (mm_valid),
        .res    (mm_res)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            raw_reg[0] <= s_data.a0;
            raw_reg[1] <= s_data.a1;
            raw_reg[2] <= s_data.a2;
            raw_reg[3] <= s_data.a3;
            raw_reg[4] <= s_data.b0;
            raw_reg[5] <= s_data.b1;
            raw_reg[6] <= s_data.b2;
            raw_reg[7] <= s_data.b3;
            raw_reg[8] <= s_data.alpha;
            inv_reg    <= (s_data.opcode == OP_INV);
            e_reg      <= E_INIT;
            c_reg[0]   <= W'(1);
            c_reg[1]   <= '0;
            c_reg[2]   <= '0;
            c_reg[3]   <= '0;
        end else begin
            if (cmd.mm_start && cmd.mm_sel == MM_RED) begin
                for (int j = 0; j < NUM_RED - 1; j++) begin
                    raw_reg[j] <= raw_reg[j+1];
                end
            end
            if (cmd.e_shift) begin
                e_reg <= e_reg >> 1;
            end
            if (cmd.t_to_c) begin
                for (int j = 0; j < 4; j++) begin
                    c_reg[j] <= t_reg[j];
                end
            end
        end

        if (cmd.red_write && cmd.red_idx == RED_IDX_W'(NUM_RED - 1)) begin
            alpha_reg <= mm_res;
        end

        if (cmd.red_write && cmd.red_idx < RED_IDX_W'(4)) begin
            x_reg[cmd.red_idx[1:0]] <= mm_res;
        end else if (cmd.t_to_x) begin
            for (int j = 0; j < 4; j++) begin
                x_reg[j] <= t_reg[j];
            end
        end else if (cmd.x_rot || cmd.yx_step) begin
            for (int j = 0; j < 3; j++) begin
                x_reg[j] <= x_reg[j+1];
            end
            x_reg[3] <= x_reg[0];
        end

        if (cmd.red_write && cmd.red_idx >= RED_IDX_W'(4)
                && cmd.red_idx < RED_IDX_W'(8)) begin
            y_reg[cmd.red_idx[1:0]] <= mm_res;
        end else if (cmd.y_from_c) begin
            for (int j = 0; j < 4; j++) begin
                y_reg[j] <= c_reg[j];
            end
        end else if (cmd.y_from_x) begin
            for (int j = 0; j < 4; j++) begin
                y_reg[j] <= x_reg[j];
            end
        end else if (cmd.acc_step) begin
            for (int j = 0; j < 3; j++) begin
                y_reg[j] <= y_reg[j+1];
            end
            y_reg[3] <= y_reg[0];
        end else if (cmd.yx_step) begin
            y_reg[0] <= mm_res;
            for (int j = 1; j < 4; j++) begin
                y_reg[j] <= y_reg[j-1];
            end
        end

        if (cmd.t_clear) begin
            for (int j = 0; j < 4; j++) begin
                t_reg[j] <= '0;
            end
        end else if (cmd.acc_step) begin
            for (int j = 0; j < 3; j++) begin
                t_reg[j] <= t_reg[j+1];
            end
            t_reg[3] <= acc_sum[W-1:0];
        end

        if (cmd.out_load) begin
            if (cmd.out_zero) begin
                out_reg.c0           <= '0;
                out_reg.c1           <= '0;
                out_reg.c2           <= '0;
                out_reg.c3           <= '0;
                out_reg.zero_operand <= 1'b1;
            end else begin
                out_reg.c0           <= center(c_reg[0]);
                out_reg.c1           <= center(c_reg[1]);
                out_reg.c2           <= center(c_reg[2]);
                out_reg.c3           <= center(c_reg[3]);
                out_reg.zero_operand <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        st.mm_valid = mm_valid;
        st.invert   = inv_reg;
        st.x_zero   = (x_reg[0] == '0) && (x_reg[1] == '0)
                   && (x_reg[2] == '0) && (x_reg[3] == '0);
        st.e_zero   = (e_reg == '0);
        st.e_lsb    = e_reg[0];
        st.out_busy = m_valid_reg && !m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== design/qemi_ctrl.sv =====
// Controller: sequences input reduction, ring products and square-and-multiply.
`timescale 1ns / 1ps

module qemi_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qemi_pkg::dp_status_t st,
    output qemi_pkg::dp_cmd_t    cmd
);

    import qemi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_ISSUE,
        ST_RED_WAIT,
        ST_DISPATCH,
        ST_LOOP,
        ST_RM_START,
        ST_RM_PROD,
        ST_RM_PROD_WAIT,
        ST_RM_ALPHA,
        ST_RM_ALPHA_WAIT,
        ST_RM_DONE,
        ST_FINISH
    } state_t;

    localparam logic [RED_IDX_W-1:0] RED_LAST = RED_IDX_W'(NUM_RED - 1);

    state_t               state_reg, state_next;
    logic [RED_IDX_W-1:0] red_cnt_reg, red_cnt_next;
    logic [1:0]           k_reg, k_next;
    logic [1:0]           i_reg, i_next;
    logic                 dest_x_reg, dest_x_next;
    logic                 zero_reg, zero_next;

    always_comb begin
        cmd          = '0;
        cmd.mm_sel   = MM_PROD;
        cmd.red_idx  = red_cnt_reg;
        cmd.out_zero = zero_reg;
        state_next   = state_reg;
        red_cnt_next = red_cnt_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        dest_x_next  = dest_x_reg;
        zero_next    = zero_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load     = 1'b1;
                    red_cnt_next = '0;
                    state_next   = ST_RED_ISSUE;
                end
            end
            ST_RED_ISSUE: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = MM_RED;
                state_next   = ST_RED_WAIT;
            end
            ST_RED_WAIT: begin
                if (st.mm_valid) begin
                    cmd.red_write = 1'b1;
                    if (red_cnt_reg == RED_LAST) begin
                        state_next = ST_DISPATCH;
                    end else begin
                        red_cnt_next = red_cnt_reg + 1'b1;
                        state_next   = ST_RED_ISSUE;
                    end
                end
            end
            ST_DISPATCH: begin
                zero_next = st.invert && st.x_zero;
                if (!st.invert) begin
                    dest_x_next = 1'b0;
                    state_next  = ST_RM_START;
                end else if (st.x_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (st.e_zero) begin
                    state_next = ST_FINISH;
                end else if (st.e_lsb) begin
                    cmd.y_from_c = 1'b1;
                    dest_x_next  = 1'b0;
                    state_next   = ST_RM_START;
                end else begin
                    cmd.y_from_x = 1'b1;
                    dest_x_next  = 1'b1;
                    state_next   = ST_RM_START;
                end
            end
            ST_RM_START: begin
                cmd.t_clear = 1'b1;
                i_next      = '0;
                k_next      = '0;
                state_next  = ST_RM_PROD;
            end
            ST_RM_PROD: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = MM_PROD;
                state_next   = ST_RM_PROD_WAIT;
            end
            ST_RM_PROD_WAIT: begin
                if (st.mm_valid) begin
                    cmd.acc_step = 1'b1;
                    k_next       = k_reg + 1'b1;
                    if (k_reg == 2'd3) begin
                        if (i_reg == 2'd3) begin
                            cmd.x_rot  = 1'b1;
                            state_next = ST_RM_DONE;
                        end else begin
                            state_next = ST_RM_ALPHA;
                        end
                    end else begin
                        state_next = ST_RM_PROD;
                    end
                end
            end
            ST_RM_ALPHA: begin
                cmd.mm_start = 1'b1;
                cmd.mm_sel   = MM_ALPHA;
                state_next   = ST_RM_ALPHA_WAIT;
            end
            ST_RM_ALPHA_WAIT: begin
                if (st.mm_valid) begin
                    cmd.yx_step = 1'b1;
                    i_next      = i_reg + 1'b1;
                    state_next  = ST_RM_PROD;
                end
            end
            ST_RM_DONE: begin
                if (dest_x_reg) begin
                    cmd.t_to_x  = 1'b1;
                    cmd.e_shift = 1'b1;
                    state_next  = ST_LOOP;
                end else begin
                    cmd.t_to_c = 1'b1;
                    if (!st.invert) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.y_from_x = 1'b1;
                        dest_x_next  = 1'b1;
                        state_next   = ST_RM_START;
                    end
                end
            end
            ST_FINISH: begin
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            red_cnt_reg <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            dest_x_reg  <= 1'b0;
            zero_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            red_cnt_reg <= red_cnt_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            dest_x_reg  <= dest_x_next;
            zero_reg    <= zero_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== design/quartic_ext_mul_inv_mod_q.sv =====
// Top level of the quartic extension multiply/invert unit mod MODULUS_Q.
`timescale 1ns / 1ps

// Multiplies or inverts one element of Z_Q[x]/(x^4 - alpha) per transaction,
// one transaction at a time. All modular products go through a single
// five-stage mulmod unit, issued one at a time. Operand reduction issues 9
// products, one ring product 19 (16 coefficient products plus 3 alpha
// products). Invert takes L plus the count of ones in Q^4-2 ring products
// after reduction (at most 2*L), with L the bit length of Q^4-2 (48 for
// Q = 3457); an all-zero operand to invert returns after reduction with
// zero_operand set. The result register frees the controller, which takes
// the next transaction while a finished one waits on m_ready.
module quartic_ext_mul_inv_mod_q #(
    parameter int MODULUS_Q = 3457
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  qemi_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output qemi_pkg::out_t m_data
);

    import qemi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    qemi_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .st     (st),
        .cmd    (cmd)
    );

    qemi_datapath #(
        .MODULUS_Q(MODULUS_Q)
    ) u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .st     (st),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule
